// File: design/piecewise_linear_interpolator_top_assert.svh
// Assertion macros shared by the interpolator RTL.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pli assertion failed");

// Next-cycle implication, checked outside reset.
`define PLI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pli assertion failed");

`endif

// File: design/pli_pkg.sv
// Shared types and codes of the piecewise linear interpolator.
`default_nettype none

package pli_pkg;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic CFG_EXTRAP = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    localparam int COUNT_WIDTH  = 9;
    localparam int INDEX_WIDTH  = 8;
    localparam int SEG_WIDTH    = 8;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_INSIDE     = 2'd0;
    localparam status_t STATUS_OUTSIDE    = 2'd1;
    localparam status_t STATUS_ZERO_WIDTH = 2'd2;
    localparam status_t STATUS_FEW_POINTS = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_SCAN,
        ST_FETCH_L,
        ST_FETCH_R,
        ST_FETCH_W,
        ST_ARITH,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        AR_IDLE,
        AR_MUL,
        AR_DIV,
        AR_FINISH
    } arith_state_t;

endpackage

`default_nettype wire

// File: design/pli_ram.sv
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/pli_arith.sv
// Serial multiply-divide unit: base + dy * dxq / dx with saturation.
`default_nettype none

module pli_arith
    import pli_pkg::*;
#(
    parameter int VW = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [VW-1:0] base,
    input  wire logic signed [VW:0]   dy,
    input  wire logic signed [VW:0]   dxq,
    input  wire logic signed [VW:0]   dx,
    output logic                      done,
    output logic signed [VW-1:0]      result
);

    localparam int PW = 2 * VW + 2;
    localparam int CW = $clog2(PW + 1);
    localparam int RW = VW + 2;

    arith_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [VW:0]   mplier_reg, mplier_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [VW:0]   div_reg, div_next;
    logic [VW-1:0] base_reg, base_next;
    logic          neg_reg, neg_next;
    logic [VW-1:0] result_reg, result_next;
    logic          done_reg, done_next;

    logic [VW:0]   dy_u, dxq_u, dx_u;
    logic [VW:0]   dy_mag, dxq_mag, dx_mag;
    logic [RW-1:0] shifted;
    logic [RW-1:0] div_ext;
    logic          fits;
    logic [RW-1:0] base_ext, q_ext, sum;
    logic          over;

    assign dy_u    = dy;
    assign dxq_u   = dxq;
    assign dx_u    = dx;
    assign dy_mag  = dy_u[VW]  ? (~dy_u  + (VW+1)'(1)) : dy_u;
    assign dxq_mag = dxq_u[VW] ? (~dxq_u + (VW+1)'(1)) : dxq_u;
    assign dx_mag  = dx_u[VW]  ? (~dx_u  + (VW+1)'(1)) : dx_u;

    assign shifted = {rem_reg[RW-2:0], prod_reg[PW-1]};
    assign div_ext = {1'b0, div_reg};
    assign fits    = (shifted >= div_ext);

    assign base_ext = {{2{base_reg[VW-1]}}, base_reg};
    assign q_ext    = {2'b00, prod_reg[VW-1:0]};
    assign sum      = neg_reg ? (base_ext - q_ext) : (base_ext + q_ext);
    assign over     = |prod_reg[PW-1:VW];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            AR_IDLE:
            begin
                if (start)
                begin
                    state_next = AR_MUL;
                end
            end
            AR_MUL:
            begin
                if (cnt_reg == CW'(VW))
                begin
                    state_next = AR_DIV;
                end
            end
            AR_DIV:
            begin
                if (cnt_reg == CW'(PW - 1))
                begin
                    state_next = AR_FINISH;
                end
            end
            AR_FINISH:
            begin
                state_next = AR_IDLE;
            end
            default:
            begin
                state_next = AR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        base_next   = base_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            AR_IDLE:
            begin
                if (start)
                begin
                    cnt_next    = '0;
                    mcand_next  = PW'(dy_mag);
                    mplier_next = dxq_mag;
                    prod_next   = '0;
                    rem_next    = '0;
                    div_next    = dx_mag;
                    base_next   = base;
                    neg_next    = dy_u[VW] ^ dxq_u[VW] ^ dx_u[VW];
                end
            end
            AR_MUL:
            begin
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[PW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[VW:1]};
                cnt_next    = (cnt_reg == CW'(VW)) ? '0 : cnt_reg + CW'(1);
            end
            AR_DIV:
            begin
                rem_next  = fits ? (shifted - div_ext) : shifted;
                prod_next = {prod_reg[PW-2:0], fits};
                cnt_next  = cnt_reg + CW'(1);
            end
            AR_FINISH:
            begin
                done_next = 1'b1;
                if (div_reg == '0)
                begin
                    // Zero-width interval: the left value stands.
                    result_next = base_reg;
                end
                else if (over)
                begin
                    result_next = neg_reg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
                end
                else if (sum[RW-1:VW-1] == '0 || sum[RW-1:VW-1] == '1)
                begin
                    result_next = sum[VW-1:0];
                end
                else
                begin
                    result_next = sum[RW-1] ? {1'b1, {(VW-1){1'b0}}}
                                            : {1'b0, {(VW-1){1'b1}}};
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AR_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        base_reg   <= base_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: design/piecewise_linear_interpolator_top.sv
// Top level of the piecewise linear interpolator: breakpoint tables and query sequencer.
//
// Usage: a request on the in channel either loads a breakpoint (mode 0: entry_index,
// entry_x, entry_y) or queries the table (mode 1: query_x). Loads give no result; a
// load at or above MAX_POINTS is dropped. A query gives one result on the out channel:
// result_y, segment_index and status.
// The cfg channel sets extrapolate_enable (index 0) and point_count (index 1); it is
// always ready. The user must see that it is written only while no query is in flight;
// the block itself does not enforce this. A query first reads the second-last breakpoint
// and, if it lies below that, scans up to point_count - 2 breakpoints (point_count
// capped at MAX_POINTS). It then fetches the interval in the ST_FETCH states, runs the
// serial multiply and restoring divide, and is written into the output register; with
// fewer than two points it skips to ST_DONE. One request is worked at a time; the next
// is taken once the result sits in the output register.
// A stalled receiver holds the result in the output register; a finished query then
// waits until that register frees up. Reset clears the control state and both config
// registers; the breakpoint memories are undefined until written.
`default_nettype none

module piecewise_linear_interpolator_top
    import pli_pkg::*;
#(
    parameter int MAX_POINTS  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [COUNT_WIDTH-1:0]        cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic [INDEX_WIDTH-1:0]        entry_index,
    input  wire logic signed [VALUE_WIDTH-1:0] entry_x,
    input  wire logic signed [VALUE_WIDTH-1:0] entry_y,
    input  wire logic signed [VALUE_WIDTH-1:0] query_x,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0]      result_y,
    output logic [SEG_WIDTH-1:0]               segment_index,
    output status_t                            status
);

`include "piecewise_linear_interpolator_top_assert.svh"

    localparam int VW = VALUE_WIDTH;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = (NW > COUNT_WIDTH) ? NW : COUNT_WIDTH;
    localparam int IW = (AW > INDEX_WIDTH) ? AW : INDEX_WIDTH;

    ctrl_state_t state_reg, state_next;

    logic                 extrap_reg, extrap_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic signed [VW-1:0] x_reg, x_next;
    logic [CW-1:0]        scan_addr_reg, scan_addr_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]        seg_reg, seg_next;
    logic signed [VW-1:0] xl_reg, xl_next;
    logic signed [VW-1:0] yl_reg, yl_next;
    logic signed [VW-1:0] res_y_reg, res_y_next;
    logic [SEG_WIDTH-1:0] res_seg_reg, res_seg_next;
    status_t              res_status_reg, res_status_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [VW-1:0] out_y_reg, out_y_next;
    logic [SEG_WIDTH-1:0] out_seg_reg, out_seg_next;
    status_t              out_status_reg, out_status_next;

    logic [CW-1:0]        count_ext, n_val, nm2;
    logic                 few;
    logic                 in_acc;
    logic [IW:0]          idx_ext;
    logic                 load_en;
    logic [AW-1:0]        rd_addr;
    logic signed [VW-1:0] rd_x, rd_y;
    logic                 hit, last;
    logic                 out_free;
    logic [IW-1:0]        seg_wide;

    logic                 below, above, zero_width;
    logic signed [VW-1:0] yl_c, yr_c;
    logic signed [VW:0]   dy_c, dxq_c, dx_c;
    logic                 arith_start, arith_done;
    logic signed [VW-1:0] arith_result;

    // Table size in use, capped at the memory depth.
    assign count_ext = CW'(count_reg);
    assign n_val     = (count_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : count_ext;
    assign nm2       = n_val - CW'(2);
    assign few       = (n_val < CW'(2));

    assign in_acc  = in_valid && in_ready;
    assign idx_ext = (IW+1)'(entry_index);
    assign load_en = in_acc && (mode == MODE_LOAD) && (idx_ext < (IW+1)'(MAX_POINTS));

    assign hit      = cmp_valid_reg && (x_reg <= rd_x);
    assign last     = cmp_valid_reg && (CW'(cmp_idx_reg) == nm2);
    assign out_free = !out_valid_reg || out_ready;
    assign seg_wide = IW'(seg_reg);

    pli_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_POINTS)
    ) u_x_ram (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data (entry_x),
        .rd_addr (rd_addr),
        .rd_data (rd_x)
    );

    pli_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_POINTS)
    ) u_y_ram (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data (entry_y),
        .rd_addr (rd_addr),
        .rd_data (rd_y)
    );

    // Interval check and clamping, evaluated as the right breakpoint arrives.
    assign below      = (x_reg < xl_reg);
    assign above      = (x_reg > rd_x);
    assign zero_width = (rd_x == xl_reg);
    assign yr_c       = (!extrap_reg && below) ? yl_reg : rd_y;
    assign yl_c       = (!extrap_reg && above) ? yr_c : yl_reg;
    assign dy_c       = {yr_c[VW-1], yr_c} - {yl_c[VW-1], yl_c};
    assign dxq_c      = {x_reg[VW-1], x_reg} - {xl_reg[VW-1], xl_reg};
    assign dx_c       = {rd_x[VW-1], rd_x} - {xl_reg[VW-1], xl_reg};

    pli_arith #(
        .VW (VW)
    ) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (arith_start),
        .base   (yl_c),
        .dy     (dy_c),
        .dxq    (dxq_c),
        .dx     (dx_c),
        .done   (arith_done),
        .result (arith_result)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && mode == MODE_QUERY)
                begin
                    state_next = few ? ST_DONE : ST_PRE;
                end
            end
            ST_PRE:
            begin
                if (n_val == CW'(2) || x_reg >= rd_x)
                begin
                    state_next = ST_FETCH_L;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = ST_FETCH_L;
                end
            end
            ST_FETCH_L:
            begin
                state_next = ST_FETCH_R;
            end
            ST_FETCH_R:
            begin
                state_next = ST_FETCH_W;
            end
            ST_FETCH_W:
            begin
                state_next = ST_ARITH;
            end
            ST_ARITH:
            begin
                if (arith_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cfg_ready       = 1'b1;
        arith_start     = 1'b0;
        rd_addr         = seg_reg;
        extrap_next     = extrap_reg;
        count_next      = count_reg;
        x_next          = x_reg;
        scan_addr_next  = scan_addr_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        seg_next        = seg_reg;
        xl_next         = xl_reg;
        yl_next         = yl_reg;
        res_y_next      = res_y_reg;
        res_seg_next    = res_seg_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_y_next      = out_y_reg;
        out_seg_next    = out_seg_reg;
        out_status_next = out_status_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_EXTRAP: extrap_next = cfg_data[0];
                CFG_COUNT:  count_next  = cfg_data;
                default:    count_next  = count_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = nm2[AW-1:0];
                if (in_acc && mode == MODE_QUERY)
                begin
                    x_next         = query_x;
                    scan_addr_next = CW'(1);
                    if (few)
                    begin
                        res_y_next      = '0;
                        res_seg_next    = '0;
                        res_status_next = STATUS_FEW_POINTS;
                    end
                end
            end
            ST_PRE:
            begin
                // The last interval is the default; the scan starts at x[1] meanwhile.
                rd_addr        = scan_addr_reg[AW-1:0];
                seg_next       = nm2[AW-1:0];
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_addr_reg[AW-1:0];
                scan_addr_next = scan_addr_reg + CW'(1);
            end
            ST_SCAN:
            begin
                rd_addr = scan_addr_reg[AW-1:0];
                if (hit)
                begin
                    seg_next = cmp_idx_reg - AW'(1);
                end
                else if (last)
                begin
                    seg_next = nm2[AW-1:0];
                end
                if (scan_addr_reg <= nm2)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_addr_reg[AW-1:0];
                    scan_addr_next = scan_addr_reg + CW'(1);
                end
            end
            ST_FETCH_L:
            begin
                rd_addr = seg_reg;
            end
            ST_FETCH_R:
            begin
                rd_addr = seg_reg + AW'(1);
                xl_next = rd_x;
                yl_next = rd_y;
            end
            ST_FETCH_W:
            begin
                arith_start  = 1'b1;
                res_seg_next = seg_wide[SEG_WIDTH-1:0];
                if (zero_width)
                begin
                    res_status_next = STATUS_ZERO_WIDTH;
                end
                else if (below || above)
                begin
                    res_status_next = STATUS_OUTSIDE;
                end
                else
                begin
                    res_status_next = STATUS_INSIDE;
                end
            end
            ST_ARITH:
            begin
                if (arith_done)
                begin
                    res_y_next = arith_result;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_y_next      = res_y_reg;
                    out_seg_next    = res_seg_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
                rd_addr = seg_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            extrap_reg    <= 1'b0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            extrap_reg    <= extrap_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        scan_addr_reg  <= scan_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        seg_reg        <= seg_next;
        xl_reg         <= xl_next;
        yl_reg         <= yl_next;
        res_y_reg      <= res_y_next;
        res_seg_reg    <= res_seg_next;
        res_status_reg <= res_status_next;
        out_y_reg      <= out_y_next;
        out_seg_reg    <= out_seg_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid     = out_valid_reg;
    assign result_y      = out_y_reg;
    assign segment_index = out_seg_reg;
    assign status        = out_status_reg;

    `PLI_ASSERT_IMP(a_done_in_arith, clk, rst_n, arith_done, state_reg == ST_ARITH)
    `PLI_ASSERT_IMP(a_seg_in_range, clk, rst_n, state_reg == ST_FETCH_L, CW'(seg_reg) <= nm2)
    `PLI_ASSERT_IMP(a_scan_needs_points, clk, rst_n, state_reg == ST_SCAN, n_val > CW'(2))
    `PLI_ASSERT_NXT(a_result_loaded, clk, rst_n, state_reg == ST_DONE && out_free, out_valid_reg)

endmodule

`default_nettype wire

// File: test/pli_result_check.sv
// Result checker for the interpolator: predicts each query result and compares it.
`timescale 1ns / 100ps

module pli_result_check
    import pli_pkg::*;
#(
    parameter int MAX_POINTS  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [COUNT_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          mode,
    input  logic [INDEX_WIDTH-1:0]        entry_index,
    input  logic signed [VALUE_WIDTH-1:0] entry_x,
    input  logic signed [VALUE_WIDTH-1:0] entry_y,
    input  logic signed [VALUE_WIDTH-1:0] query_x,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [VALUE_WIDTH-1:0] result_y,
    input  logic [SEG_WIDTH-1:0]          segment_index,
    input  status_t                       status,
    output int                            fail_count,
    output int                            pending
);

    localparam longint LIM_HI = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
    localparam longint LIM_LO = -LIM_HI - 1;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] y;
        logic [SEG_WIDTH-1:0]          seg;
        status_t                       st;
    } interp_result_t;

    logic signed [VALUE_WIDTH-1:0] bp_x [MAX_POINTS];
    logic signed [VALUE_WIDTH-1:0] bp_y [MAX_POINTS];
    logic                          extrap_en = 1'b0;
    logic [COUNT_WIDTH-1:0]        point_count = '0;

    interp_result_t expected_q [$];
    interp_result_t want;
    interp_result_t got;
    int             mismatches = 0;

    function automatic logic [127:0] magnitude(input longint a);
        return (a < 0) ? 128'(-a) : 128'(a);
    endfunction

    function automatic interp_result_t interpolate(input logic signed [VALUE_WIDTH-1:0] qx);
        interp_result_t res;
        int             n;
        int             seg;
        int             k;
        bit             found;
        bit             neg;
        longint         xq, xl, xr, yl, yr, dy, dxq, dx, v;
        logic [127:0]   prod, quot;
        res.y   = '0;
        res.seg = '0;
        res.st  = STATUS_INSIDE;
        n = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
        if (n < 2)
        begin
            res.st = STATUS_FEW_POINTS;
            return res;
        end
        xq    = qx;
        seg   = n - 2;
        found = 1'b0;
        // The last interval covers everything at or above the second-last breakpoint.
        if (xq < longint'(bp_x[n-2]))
        begin
            for (k = 0; k + 2 < n && !found; k++)
            begin
                if (xq <= longint'(bp_x[k+1]))
                begin
                    seg   = k;
                    found = 1'b1;
                end
            end
        end
        xl = bp_x[seg];
        xr = bp_x[seg+1];
        yl = bp_y[seg];
        yr = bp_y[seg+1];
        if (xq < xl || xq > xr)
            res.st = STATUS_OUTSIDE;
        if (!extrap_en)
        begin
            if (xq < xl)
                yr = yl;
            if (xq > xr)
                yl = yr;
        end
        if (xr == xl)
        begin
            res.st = STATUS_ZERO_WIDTH;
            v = yl;
        end
        else
        begin
            dy   = yr - yl;
            dxq  = xq - xl;
            dx   = xr - xl;
            neg  = ((dy < 0) != (dxq < 0)) != (dx < 0);
            prod = magnitude(dy) * magnitude(dxq);
            quot = prod / magnitude(dx);
            if (dy == 0 || dxq == 0)
                v = yl;
            else if (quot > (128'd1 << 60))
                v = neg ? LIM_LO : LIM_HI;
            else
                v = neg ? yl - longint'(quot[63:0]) : yl + longint'(quot[63:0]);
        end
        if (v > LIM_HI)
            v = LIM_HI;
        if (v < LIM_LO)
            v = LIM_LO;
        res.y   = v[VALUE_WIDTH-1:0];
        res.seg = seg[SEG_WIDTH-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extrap_en   = 1'b0;
            point_count = '0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_EXTRAP)
                    extrap_en = cfg_data[0];
                else if (cfg_index == CFG_COUNT)
                    point_count = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                got.y   = result_y;
                got.seg = segment_index;
                got.st  = status;
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with no query waiting: y=%h seg=%0d status=%0d",
                                 $time, got.y, got.seg, got.st);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.y !== want.y || got.seg !== want.seg || got.st !== want.st)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch: expected y=%h seg=%0d status=%0d, ",
                                      "got y=%h seg=%0d status=%0d"}, $time,
                                     want.y, want.seg, want.st, got.y, got.seg, got.st);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (mode == MODE_LOAD)
                begin
                    if (entry_index < MAX_POINTS)
                    begin
                        bp_x[entry_index] = entry_x;
                        bp_y[entry_index] = entry_y;
                    end
                end
                else
                    expected_q.insert(expected_q.size(), interpolate(query_x));
            end
        end
        pending    <= expected_q.size();
        fail_count <= mismatches;
    end

endmodule

// File: test/tb_piecewise_linear_interpolator_top.sv
// Testbench top: drives load, query and register requests into the interpolator.
`timescale 1ns / 100ps

module tb_piecewise_linear_interpolator_top;
    import pli_pkg::*;

    localparam int MAX_POINTS     = 256;
    localparam int VALUE_WIDTH    = 32;
    localparam int CLK_PERIOD     = 20;
    localparam int REQUEST_TARGET = 1200;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int DRAIN_CYCLES   = 400;

    localparam logic signed [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_index   = CFG_EXTRAP;
    logic [COUNT_WIDTH-1:0]        cfg_data    = '0;
    logic                          in_valid    = 1'b0;
    logic                          mode        = MODE_LOAD;
    logic [INDEX_WIDTH-1:0]        entry_index = '0;
    logic signed [VALUE_WIDTH-1:0] entry_x     = '0;
    logic signed [VALUE_WIDTH-1:0] entry_y     = '0;
    logic signed [VALUE_WIDTH-1:0] query_x     = '0;
    logic                          out_ready   = 1'b0;
    logic                          cfg_ready;
    logic                          in_ready;
    logic                          out_valid;
    logic signed [VALUE_WIDTH-1:0] result_y;
    logic [SEG_WIDTH-1:0]          segment_index;
    status_t                       status;

    int fail_count;
    int pending;

    logic signed [VALUE_WIDTH-1:0] tab_x [MAX_POINTS];
    logic signed [VALUE_WIDTH-1:0] tab_y [MAX_POINTS];
    bit                            written [MAX_POINTS];

    int          requests_sent = 0;
    int          active_count  = 0;
    int          cycle_count   = 0;
    bit          quiet         = 1'b0;
    int unsigned in_gap_pct    = 0;
    int unsigned out_stall_pct = 0;
    int unsigned ready_hold    = 0;
    int unsigned pct_levels [4] = '{0, 10, 30, 60};

    always #(CLK_PERIOD / 2) clk = ~clk;

    piecewise_linear_interpolator_top #(
        .MAX_POINTS  (MAX_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .entry_index   (entry_index),
        .entry_x       (entry_x),
        .entry_y       (entry_y),
        .query_x       (query_x),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_y      (result_y),
        .segment_index (segment_index),
        .status        (status)
    );

    pli_result_check #(
        .MAX_POINTS  (MAX_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .entry_index   (entry_index),
        .entry_x       (entry_x),
        .entry_y       (entry_y),
        .query_x       (query_x),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_y      (result_y),
        .segment_index (segment_index),
        .status        (status),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Receiver back-pressure comes in bursts.
    always @(posedge clk)
    begin
        if (quiet)
        begin
            ready_hold <= 0;
            out_ready  <= 1'b1;
        end
        else if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end
        else if ($urandom_range(99) < out_stall_pct)
        begin
            ready_hold <= $urandom_range(17, 0);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_request(input logic m, input logic [INDEX_WIDTH-1:0] idx,
                                input logic signed [VALUE_WIDTH-1:0] ex,
                                input logic signed [VALUE_WIDTH-1:0] ey,
                                input logic signed [VALUE_WIDTH-1:0] qx);
        int unsigned gap;
        gap = (!quiet && $urandom_range(99) < in_gap_pct) ? $urandom_range(18, 1) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        entry_index <= idx;
        entry_x     <= ex;
        entry_y     <= ey;
        query_x     <= qx;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    task automatic load_point(input logic [INDEX_WIDTH-1:0] idx,
                              input logic signed [VALUE_WIDTH-1:0] px,
                              input logic signed [VALUE_WIDTH-1:0] py);
        tab_x[idx]   = px;
        tab_y[idx]   = py;
        written[idx] = 1'b1;
        send_request(MODE_LOAD, idx, px, py, $urandom);
    endtask

    task automatic query_at(input logic signed [VALUE_WIDTH-1:0] qx);
        send_request(MODE_QUERY, INDEX_WIDTH'($urandom), $urandom, $urandom, qx);
    endtask

    // Lets every outstanding query finish and a trailing load retire.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic extrap, input int count);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_EXTRAP;
        cfg_data  <= {(COUNT_WIDTH-1)'($urandom), extrap};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_COUNT;
        cfg_data  <= COUNT_WIDTH'(count);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        active_count = (count > MAX_POINTS) ? MAX_POINTS : count;
    endtask

    // Writes entries 0..n-1 with non-decreasing abscissas at a random scale.
    task automatic load_table(input int n);
        int                            k;
        int unsigned                   y_style;
        bit                            dups;
        longint                        step_max;
        longint                        cur;
        logic signed [VALUE_WIDTH-1:0] yv;
        case ($urandom_range(3))
            0:       step_max = 16;
            1:       step_max = 4096;
            2:       step_max = 1 << 20;
            default: step_max = (longint'(1) << 32) / n;
        endcase
        dups    = ($urandom_range(3) == 0);
        y_style = $urandom_range(2);
        case ($urandom_range(2))
            0:       cur = V_MIN;
            1:       cur = -(longint'(n) * step_max) / 2 + longint'($urandom_range(1000));
            default: cur = int'($urandom);
        endcase
        for (k = 0; k < n; k++)
        begin
            if (cur > V_MAX)
                cur = V_MAX;
            if (cur < V_MIN)
                cur = V_MIN;
            case (y_style)
                0:       yv = $urandom;
                1:       yv = int'($urandom_range(131072)) - 65536;
                default: yv = ($urandom_range(2) == 0) ? $urandom :
                              ($urandom_range(1) ? V_MAX : V_MIN);
            endcase
            load_point(INDEX_WIDTH'(k), cur[VALUE_WIDTH-1:0], yv);
            if (!(dups && $urandom_range(5) == 0))
                cur += longint'($urandom_range(32'(step_max), 1));
        end
    endtask

    function automatic logic signed [VALUE_WIDTH-1:0] pick_query();
        int     k;
        longint lo;
        longint hi;
        if (active_count < 2)
            return $urandom;
        k = $urandom_range(active_count - 2);
        case ($urandom_range(8))
            0: return tab_x[k];
            1: return tab_x[k+1] + 1;
            2: return tab_x[k] - 1;
            3, 4:
            begin
                lo = tab_x[k];
                hi = tab_x[k+1];
                if (hi < lo)
                begin
                    lo = tab_x[k+1];
                    hi = tab_x[k];
                end
                return VALUE_WIDTH'(lo + longint'($urandom) % (hi - lo + 1));
            end
            5: return $urandom_range(1) ? V_MIN : V_MAX;
            6: return VALUE_WIDTH'(longint'(tab_x[0]) - longint'($urandom_range(1 << 20)));
            7: return VALUE_WIDTH'(longint'(tab_x[active_count-1])
                                   + longint'($urandom_range(1 << 20)));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("piecewise_linear_interpolator_top test failed");
        $finish;
    end

    initial
    begin : stimulus
        int          n;
        int          k;
        int          i;
        int          reps;
        int unsigned pick;
        bit          table_ok;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, then a single point: both report too few points.
        query_at(V_MAX);
        configure(1'b0, 1);
        query_at(V_MIN);

        // Three points whose second interval has zero width, then a fourth point.
        load_point(0, -32'sd65536, V_MIN);
        load_point(1, 32'sd0, V_MAX);
        load_point(2, 32'sd0, 32'sd12345);
        load_point(3, 32'sd65536, -32'sd7);
        configure(1'b0, 3);
        query_at(32'sd0);
        query_at(32'sd100000);
        query_at(-32'sd200000);
        query_at(V_MIN);
        query_at(-32'sd1);
        configure(1'b1, 3);
        query_at(32'sd100000);
        query_at(V_MIN);
        configure(1'b1, 4);
        query_at(V_MAX);
        query_at(32'sd32769);
        query_at(-32'sd32769);
        configure(1'b0, 4);
        query_at(V_MAX);
        query_at(32'sd65536);

        // Full-range interval with extreme ordinates.
        load_point(0, V_MIN, V_MAX);
        load_point(1, V_MAX, V_MIN);
        configure(1'b1, 2);
        query_at(V_MIN);
        query_at(V_MAX);
        query_at(32'sd0);

        while (requests_sent < REQUEST_TARGET)
        begin
            pick = $urandom_range(99);
            if (!written[MAX_POINTS-1])
                n = MAX_POINTS;
            else if (pick < 5)
                n = $urandom_range(1);
            else if (pick < 10)
                n = $urandom_range(511, 257);
            else if (pick < 15)
                n = $urandom_range(256, 17);
            else
                n = $urandom_range(12, 2);
            in_gap_pct    <= pct_levels[$urandom_range(3)];
            out_stall_pct <= pct_levels[$urandom_range(3)];
            if (requests_sent > REQUEST_TARGET - 120)
                quiet <= 1'b1;

            k = (n > MAX_POINTS) ? MAX_POINTS : n;
            table_ok = 1'b1;
            for (i = 0; i < k; i++)
                if (!written[i])
                    table_ok = 1'b0;
            if (k >= 2 && (!table_ok || (k <= 16 && $urandom_range(9) < 7)))
                load_table(k);
            // Stray loads break the ordering of the table now and then.
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(3, 1))
                    load_point(INDEX_WIDTH'($urandom), $urandom, $urandom);
            configure($urandom_range(1), n);

            reps = (k > 16) ? $urandom_range(10, 4) : $urandom_range(30, 8);
            repeat (reps)
            begin
                if ($urandom_range(19) == 0)
                    load_point(INDEX_WIDTH'($urandom), $urandom, $urandom);
                else
                    query_at(pick_query());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("piecewise_linear_interpolator_top test passed");
        else
            $display("piecewise_linear_interpolator_top test failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/pli_pkg.sv
design/pli_ram.sv
design/pli_arith.sv
design/piecewise_linear_interpolator_top.sv
test/pli_result_check.sv
test/tb_piecewise_linear_interpolator_top.sv
